FILE: hdl/cosl_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package cosl_pkg;

    // Field widths
    localparam int COORD_WIDTH     = 16;
    localparam int VEL_WIDTH       = 16;
    localparam int HW_WIDTH        = 15;
    localparam int DIST_WIDTH      = 31;
    localparam int MIN_WIDTH       = 32;
    localparam int STATUS_WIDTH    = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 31;

    // Derived widths for squaring and comparing
    localparam int SQ_WIDTH      = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH     = SQ_WIDTH + 1;
    localparam int EXT_WIDTH     = (SUM_WIDTH > MIN_WIDTH) ? SUM_WIDTH : MIN_WIDTH;
    localparam int MAG_CMP_WIDTH = (COORD_WIDTH > HW_WIDTH) ? COORD_WIDTH : HW_WIDTH;

    // Divider widths: quotient is below the positive speed
    localparam int QUO_WIDTH  = VEL_WIDTH - 1;
    localparam int PROD_WIDTH = QUO_WIDTH + DIST_WIDTH;
    localparam int CNT_WIDTH  = $clog2(QUO_WIDTH);
    localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(QUO_WIDTH - 1);

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STOP_DIST  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOW_DIST  = 2'd2;

    // Register reset values
    localparam logic [HW_WIDTH-1:0]   HALF_WIDTH_RST = 15'd819;
    localparam logic [DIST_WIDTH-1:0] STOP_DIST_RST  = 31'd3355443;
    localparam logic [DIST_WIDTH-1:0] SLOW_DIST_RST  = 31'd10066330;
    localparam logic [MIN_WIDTH-1:0]  MIN_NONE       = '1;

    // Limit status codes
    localparam logic [STATUS_WIDTH-1:0] STAT_PASS    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_SCALED  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_STOPPED = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic cap_point;
        logic cap_vel;
        logic upd_min;
        logic decide;
        logic div_step;
        logic load_out;
    } cosl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scale;
    } cosl_stat_t;

endpackage

FILE: hdl/corridor_obstacle_speed_limiter_core.sv
// Top level of the corridor obstacle speed limiter.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | mode, first_point, point_x, point_y,
//           |                      | linear_vel, angular_vel
//  out      | out_valid/out_ready  | out_linear_vel, out_angular_vel, limit_status
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// Point items are taken one per cycle unless a velocity item is in progress:
// squares are registered, then summed and folded into the running minimum
// in the next cycle while the next item enters. A velocity item holds off input
// until done; if scaled, a restoring divider yields one quotient bit per cycle.
// Reset puts the registers at their defaults and the minimum at all ones.
// A result waiting on out_ready does not stall point items.
`timescale 1ns / 1ps
module corridor_obstacle_speed_limiter_core
    import cosl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic                          first_point,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [VEL_WIDTH-1:0]   linear_vel,
    input  logic signed [VEL_WIDTH-1:0]   angular_vel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VEL_WIDTH-1:0]   out_linear_vel,
    output logic signed [VEL_WIDTH-1:0]   out_angular_vel,
    output logic [STATUS_WIDTH-1:0]       limit_status
);

    cosl_cmd_t  cmd;
    cosl_stat_t stat;

    // Sequence items
    cosl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Compute distances and limits
    cosl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .first_point     (first_point),
        .point_x         (point_x),
        .point_y         (point_y),
        .linear_vel      (linear_vel),
        .angular_vel     (angular_vel),
        .cmd             (cmd),
        .stat            (stat),
        .out_linear_vel  (out_linear_vel),
        .out_angular_vel (out_angular_vel),
        .limit_status    (limit_status)
    );

endmodule

FILE: hdl/cosl_datapath.sv
// Datapath: config registers, squared distance minimum, multiply and restoring divide.
`timescale 1ns / 1ps
module cosl_datapath
    import cosl_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
    input  logic                              first_point,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [VEL_WIDTH-1:0]       linear_vel,
    input  logic signed [VEL_WIDTH-1:0]       angular_vel,
    input  cosl_cmd_t                         cmd,
    output cosl_stat_t                        stat,
    output logic signed [VEL_WIDTH-1:0]       out_linear_vel,
    output logic signed [VEL_WIDTH-1:0]       out_angular_vel,
    output logic [STATUS_WIDTH-1:0]           limit_status
);

    logic [HW_WIDTH-1:0]    half_width_reg;
    logic [DIST_WIDTH-1:0]  stop_dist_reg;
    logic [DIST_WIDTH-1:0]  slow_dist_reg;
    logic [MIN_WIDTH-1:0]   min_reg;
    logic [MIN_WIDTH-1:0]   min_next;

    logic                   first_reg;
    logic                   in_corridor_reg;
    logic [SQ_WIDTH-1:0]    sqx_reg;
    logic [SQ_WIDTH-1:0]    sqy_reg;

    logic [VEL_WIDTH-1:0]   vel_reg;
    logic [VEL_WIDTH-1:0]   ang_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [STATUS_WIDTH-1:0] status_next;
    logic [DIST_WIDTH-1:0]  den_reg;
    logic [PROD_WIDTH-1:0]  acc_reg;
    logic [PROD_WIDTH-1:0]  acc_next;

    logic [VEL_WIDTH-1:0]   out_lin_reg;
    logic [VEL_WIDTH-1:0]   out_lin_next;
    logic [VEL_WIDTH-1:0]   out_ang_reg;
    logic [STATUS_WIDTH-1:0] out_stat_reg;

    logic [COORD_WIDTH-1:0] x_mag;
    logic [COORD_WIDTH-1:0] y_mag;
    logic                   in_corridor;
    logic [SUM_WIDTH-1:0]   dist_sum;
    logic [EXT_WIDTH-1:0]   dist_ext;
    logic [MIN_WIDTH-1:0]   dist_sat;
    logic [MIN_WIDTH-1:0]   min_base;

    logic                   vel_pos;
    logic                   is_stop;
    logic                   is_scale;
    logic [MIN_WIDTH-1:0]   num_full;

    logic [DIST_WIDTH-1:0]  div_rem;
    logic [DIST_WIDTH:0]    div_trial;
    logic                   div_ge;
    logic [DIST_WIDTH:0]    div_diff;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_WIDTH_RST;
            stop_dist_reg  <= STOP_DIST_RST;
            slow_dist_reg  <= SLOW_DIST_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[HW_WIDTH-1:0];
                CFG_STOP_DIST:  stop_dist_reg  <= cfg_data[DIST_WIDTH-1:0];
                CFG_SLOW_DIST:  slow_dist_reg  <= cfg_data[DIST_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    // Take magnitudes and test the corridor
    assign x_mag  = point_x[COORD_WIDTH-1] ? (~point_x + 1'b1) : point_x;
    assign y_mag  = point_y[COORD_WIDTH-1] ? (~point_y + 1'b1) : point_y;
    assign in_corridor = !point_x[COORD_WIDTH-1] && (point_x != '0)
                         && (MAG_CMP_WIDTH'(y_mag) < MAG_CMP_WIDTH'(half_width_reg));

    // Register squares of the point
    always_ff @(posedge clk)
    begin
        if (cmd.cap_point)
        begin
            first_reg       <= first_point;
            in_corridor_reg <= in_corridor;
            sqx_reg         <= SQ_WIDTH'(x_mag) * SQ_WIDTH'(x_mag);
            sqy_reg         <= SQ_WIDTH'(y_mag) * SQ_WIDTH'(y_mag);
        end
    end

    // Sum, saturate and fold into the running minimum
    assign dist_sum = SUM_WIDTH'(sqx_reg) + SUM_WIDTH'(sqy_reg);
    assign dist_ext = EXT_WIDTH'(dist_sum);
    assign dist_sat = (dist_ext > EXT_WIDTH'(MIN_NONE)) ? MIN_NONE
                                                        : dist_ext[MIN_WIDTH-1:0];
    assign min_base = first_reg ? MIN_NONE : min_reg;

    always_comb
    begin
        min_next = min_reg;
        if (cmd.upd_min)
        begin
            min_next = (in_corridor_reg && (dist_sat < min_base)) ? dist_sat : min_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_NONE;
        end
        else
        begin
            min_reg <= min_next;
        end
    end

    // Hold the velocity item
    always_ff @(posedge clk)
    begin
        if (cmd.cap_vel)
        begin
            vel_reg <= linear_vel;
            ang_reg <= angular_vel;
        end
    end

    // Classify the speed against the thresholds
    assign vel_pos  = !vel_reg[VEL_WIDTH-1] && (vel_reg != '0);
    assign is_stop  = vel_pos && (min_reg < MIN_WIDTH'(stop_dist_reg));
    assign is_scale = vel_pos && !is_stop && (slow_dist_reg > stop_dist_reg)
                      && (min_reg < MIN_WIDTH'(slow_dist_reg));
    assign num_full = min_reg - MIN_WIDTH'(stop_dist_reg);
    assign stat.scale = is_scale;

    always_comb
    begin
        if (is_stop)
        begin
            status_next = STAT_STOPPED;
        end
        else if (is_scale)
        begin
            status_next = STAT_SCALED;
        end
        else
        begin
            status_next = STAT_PASS;
        end
    end

    // One restoring divide step per cycle
    assign div_rem   = acc_reg[PROD_WIDTH-1 -: DIST_WIDTH];
    assign div_trial = {div_rem, acc_reg[QUO_WIDTH-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};
    assign div_diff  = div_ge ? (div_trial - {1'b0, den_reg}) : div_trial;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.decide)
        begin
            acc_next = PROD_WIDTH'(vel_reg[QUO_WIDTH-1:0])
                       * PROD_WIDTH'(num_full[DIST_WIDTH-1:0]);
        end
        else if (cmd.div_step)
        begin
            acc_next = {div_diff[DIST_WIDTH-1:0], acc_reg[QUO_WIDTH-2:0], div_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.decide)
        begin
            status_reg <= status_next;
            den_reg    <= slow_dist_reg - stop_dist_reg;
        end
    end

    // Select the limited speed
    always_comb
    begin
        case (status_reg)
            STAT_SCALED:  out_lin_next = {1'b0, acc_reg[QUO_WIDTH-1:0]};
            STAT_STOPPED: out_lin_next = '0;
            default:      out_lin_next = vel_reg;
        endcase
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_lin_reg  <= out_lin_next;
            out_ang_reg  <= ang_reg;
            out_stat_reg <= status_reg;
        end
    end

    assign out_linear_vel  = out_lin_reg;
    assign out_angular_vel = out_ang_reg;
    assign limit_status    = out_stat_reg;

endmodule

FILE: hdl/cosl_ctrl.sv
// Controller: handshakes, item sequencing and divider step count.
`timescale 1ns / 1ps
module cosl_ctrl
    import cosl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    output logic       out_valid,
    input  logic       out_ready,
    input  cosl_stat_t stat,
    output cosl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 accept;
    logic                 out_free;

    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_SQ);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Sequence items and issue datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.cap_point = accept && !mode;
        cmd.cap_vel   = accept && mode;
        case (state_reg)
            ST_IDLE, ST_SQ:
            begin
                cmd.upd_min = (state_reg == ST_SQ);
                if (accept)
                begin
                    state_next = mode ? ST_MUL : ST_SQ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = stat.scale ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Track the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the corridor obstacle speed limiter core.
`timescale 1ns / 1ps
module tb_top;
    import cosl_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] lin;
        logic signed [VEL_WIDTH-1:0] ang;
        logic [STATUS_WIDTH-1:0]     status;
    } speed_cmd_t;

    // Clock, reset and block ports
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          mode = 1'b0;
    logic                          first_point = 1'b0;
    logic signed [COORD_WIDTH-1:0] point_x = '0;
    logic signed [COORD_WIDTH-1:0] point_y = '0;
    logic signed [VEL_WIDTH-1:0]   linear_vel = '0;
    logic signed [VEL_WIDTH-1:0]   angular_vel = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VEL_WIDTH-1:0]   out_linear_vel;
    logic signed [VEL_WIDTH-1:0]   out_angular_vel;
    logic [STATUS_WIDTH-1:0]       limit_status;

    // Shadow of the block's registers and running minimum
    logic [HW_WIDTH-1:0]   half_w = HALF_WIDTH_RST;
    logic [DIST_WIDTH-1:0] stop_sq = STOP_DIST_RST;
    logic [DIST_WIDTH-1:0] slow_sq = SLOW_DIST_RST;
    logic [MIN_WIDTH-1:0]  nearest_sq = MIN_NONE;

    speed_cmd_t limited_cmd_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cmds_checked = 0;
    int settings_run = 1;
    int errors = 0;
    int idle_cycles = 0;
    int status_seen[3] = '{0, 0, 0};

    corridor_obstacle_speed_limiter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .first_point     (first_point),
        .point_x         (point_x),
        .point_y         (point_y),
        .linear_vel      (linear_vel),
        .angular_vel     (angular_vel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_linear_vel  (out_linear_vel),
        .out_angular_vel (out_angular_vel),
        .limit_status    (limit_status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one point into the running minimum
    function automatic void fold_point(input logic first,
                                       input logic signed [COORD_WIDTH-1:0] x,
                                       input logic signed [COORD_WIDTH-1:0] y);
        longint xl;
        longint yl;
        longint d;
        xl = x;
        yl = y;
        if (yl < 0)
            yl = -yl;
        if (first)
            nearest_sq = MIN_NONE;
        if (xl > 0 && yl < longint'(half_w))
        begin
            d = xl * xl + yl * yl;
            if (d > longint'(MIN_NONE))
                d = longint'(MIN_NONE);
            if (d < longint'(nearest_sq))
                nearest_sq = 32'(d);
        end
    endfunction

    // Limit a speed command against the nearest obstacle
    function automatic speed_cmd_t limit_speed(input logic signed [VEL_WIDTH-1:0] v,
                                               input logic signed [VEL_WIDTH-1:0] w);
        speed_cmd_t r;
        longint num;
        longint den;
        r.lin = v;
        r.ang = w;
        r.status = STAT_PASS;
        if (v > 0)
        begin
            if (nearest_sq < stop_sq)
            begin
                r.lin = '0;
                r.status = STAT_STOPPED;
            end
            else if (slow_sq > stop_sq && nearest_sq < slow_sq)
            begin
                num = longint'(nearest_sq) - longint'(stop_sq);
                den = longint'(slow_sq) - longint'(stop_sq);
                r.lin = VEL_WIDTH'((longint'(v) * num) / den);
                r.status = STAT_SCALED;
            end
        end
        return r;
    endfunction

    // Offer one item, hold it until taken, then update the prediction
    task automatic send_item(input logic m, input logic f,
                             input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [VEL_WIDTH-1:0] v,
                             input logic signed [VEL_WIDTH-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        first_point <= f;
        point_x     <= x;
        point_y     <= y;
        linear_vel  <= v;
        angular_vel <= w;
        do
            @(posedge clk);
        while (!in_ready);
        if (m)
            limited_cmd_q.push_back(limit_speed(v, w));
        else
            fold_point(f, x, y);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_point(input logic f, input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y);
        send_item(1'b0, f, x, y, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_cmd(input logic signed [VEL_WIDTH-1:0] v,
                            input logic signed [VEL_WIDTH-1:0] w, input logic f);
        send_item(1'b1, f, 16'($urandom), 16'($urandom), v, w);
    endtask

    // Drop valid, drain all expected results, then let the point pipeline empty
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (limited_cmd_q.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_HALF_WIDTH: half_w  = data[HW_WIDTH-1:0];
            CFG_STOP_DIST:  stop_sq = data[DIST_WIDTH-1:0];
            CFG_SLOW_DIST:  slow_sq = data[DIST_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input int unsigned half, input int unsigned stop,
                              input int unsigned slow);
        wait_quiet();
        write_reg(CFG_HALF_WIDTH, 31'(half));
        write_reg(CFG_STOP_DIST, 31'(stop));
        write_reg(CFG_SLOW_DIST, 31'(slow));
        settings_run++;
    endtask

    // Corridor bounds, restarts and every limit region at reset settings
    task automatic test_reset_defaults();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        send_cmd(16'sd32767, -16'sd32768, 1'b0);
        send_cmd(-16'sd32768, 16'sd32767, 1'b1);
        send_point(1'b1, 16'sd0, 16'sd0);
        send_point(1'b0, -16'sd32768, 16'sd0);
        send_point(1'b0, 16'sd100, 16'sd819);
        send_point(1'b0, 16'sd100, -16'sd32768);
        send_cmd(16'sd100, 16'sd5, 1'b0);
        send_point(1'b0, 16'sd3000, -16'sd818);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
        send_cmd(16'sd0, 16'sd1, 1'b0);
        send_cmd(-16'sd1, -16'sd1, 1'b0);
        send_point(1'b0, 16'sd1000, 16'sd0);
        send_cmd(16'sd1, 16'sd0, 1'b0);
        send_cmd(16'sd32767, 16'sd7, 1'b1);
        send_point(1'b1, 16'sd32767, 16'sd818);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
        send_point(1'b1, 16'sd40, 16'sd40);
        send_point(1'b0, 16'sd1, -16'sd1);
        send_cmd(16'sd1, 16'sd0, 1'b0);
        send_point(1'b1, 16'sd1832, 16'sd0);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
        send_point(1'b1, 16'sd3172, 16'sd0);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
        send_point(1'b1, -16'sd1, 16'sd0);
        send_cmd(16'sd5, 16'sd0, 1'b0);
    endtask

    // Widest scaling products and the edges of the scaling band
    task automatic test_scale_edges();
        set_limits(32767, 0, 32'h7FFF_FFFF);
        send_point(1'b1, 16'sd32767, 16'sd32766);
        send_cmd(16'sd32767, 16'sd3, 1'b0);
        send_point(1'b1, 16'sd32767, -16'sd32767);
        send_cmd(16'sd32767, -16'sd3, 1'b0);
        set_limits(32767, 1000000, 2000000);
        // unused register index: must leave the limits alone
        write_reg(2'd3, 31'($urandom));
        send_point(1'b1, 16'sd1000, 16'sd0);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
        send_point(1'b1, 16'sd1414, 16'sd0);
        send_cmd(-16'sd5, 16'sd0, 1'b0);
        send_cmd(16'sd32767, 16'sd0, 1'b0);
    endtask

    // Mostly well-formed clouds followed by a command, plus random noise items
    task automatic test_random_traffic(input int n_items, input int reach);
        int stop_at;
        int pts;
        int yl;
        int r;
        logic fresh;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        for (int q = 0; q < 4; q++)
        begin
            case (q)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            stop_at = items_sent + n_items / 4;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(99) < 75)
                begin
                    pts = $urandom_range(8, 1);
                    fresh = ($urandom_range(99) < 80);
                    for (int i = 0; i < pts; i++)
                    begin
                        yl = int'(half_w) + 64;
                        if (yl > 32767)
                            yl = 32767;
                        y = COORD_WIDTH'(int'($urandom_range(2 * yl)) - yl);
                        r = $urandom_range(99);
                        if (r < 70)
                            x = COORD_WIDTH'($urandom_range(reach, 1));
                        else if (r < 85)
                            x = COORD_WIDTH'(-int'($urandom_range(reach, 0)));
                        else
                        begin
                            x = COORD_WIDTH'($urandom);
                            y = COORD_WIDTH'($urandom);
                        end
                        send_point(fresh && i == 0, x, y);
                    end
                    if ($urandom_range(99) < 85)
                        send_cmd(VEL_WIDTH'($urandom_range(32767, 1)), 16'($urandom),
                                 1'($urandom));
                    else
                        send_cmd(16'($urandom), 16'($urandom), 1'($urandom));
                end
                else
                    send_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Receiver stall pattern
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        speed_cmd_t exp_cmd;
        if (rst_n && out_valid && out_ready)
        begin
            if (limited_cmd_q.size() == 0)
            begin
                $error("result with no command pending: lin %0d ang %0d status %0d",
                       out_linear_vel, out_angular_vel, limit_status);
                errors++;
            end
            else
            begin
                exp_cmd = limited_cmd_q.pop_front();
                cmds_checked++;
                if (exp_cmd.status < 3)
                    status_seen[exp_cmd.status]++;
                if (out_linear_vel !== exp_cmd.lin)
                begin
                    $error("out_linear_vel: expected %0d, got %0d", exp_cmd.lin,
                           out_linear_vel);
                    errors++;
                end
                if (out_angular_vel !== exp_cmd.ang)
                begin
                    $error("out_angular_vel: expected %0d, got %0d", exp_cmd.ang,
                           out_angular_vel);
                    errors++;
                end
                if (limit_status !== exp_cmd.status)
                begin
                    $error("limit_status: expected %0d, got %0d", exp_cmd.status,
                           limit_status);
                    errors++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, limited_cmd_q.size());
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_scale_edges();

        set_limits(HALF_WIDTH_RST, STOP_DIST_RST, SLOW_DIST_RST);
        test_random_traffic(272, 3400);
        set_limits(32767, 0, 32'h7FFF_FFFF);
        test_random_traffic(272, 32767);
        set_limits(0, $urandom_range(32'h00FF_FFFF), $urandom_range(32'h7FFF_FFFF));
        test_random_traffic(272, 4000);
        set_limits(2000, 20000000, 5000000);
        test_random_traffic(272, 6000);
        set_limits(819, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        test_random_traffic(272, 2000);
        begin
            int unsigned rnd_stop;
            rnd_stop = $urandom_range(32'h0400_0000);
            set_limits($urandom_range(32767, 100), rnd_stop,
                       rnd_stop + $urandom_range(32'h0800_0000));
        end
        test_random_traffic(272, 12000);

        wait_quiet();
        repeat (20) @(negedge clk);

        $display("Sent %0d items under %0d limit settings; checked %0d speed commands",
                 items_sent, settings_run, cmds_checked);
        $display("Commands passed %0d, scaled %0d, stopped %0d; %0d mismatches",
                 status_seen[0], status_seen[1], status_seen[2], errors);
        if (errors == 0 && limited_cmd_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
